// ----- hw/rtl/mtf_pkg.sv -----
// Shared constants and the token type handed along the move-to-front cell row.
package mtf_pkg;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned DEF_ALPHABET_SIZE = 256;

  typedef struct packed {
    logic             active;
    logic             found;
    logic [SYM_W-1:0] val;
    logic [SYM_W-1:0] pos;
  } mtf_tok_t;

endpackage

// ----- hw/rtl/mtf_in_if.sv -----
// Input channel carrying one symbol word and its last-of-block flag.
interface mtf_in_if import mtf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_in;
  logic             last_of_block;

  modport source (output valid, output symbol_in, output last_of_block, input ready);
  modport sink (input valid, input symbol_in, input last_of_block, output ready);
endinterface

// ----- hw/rtl/mtf_out_if.sv -----
// Output channel carrying one result word.
interface mtf_out_if import mtf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] value_out;

  modport source (output valid, output value_out, input ready);
  modport sink (input valid, input value_out, output ready);
endinterface

// ----- hw/rtl/mtf_cfg_if.sv -----
// Configuration write channel carrying the mode register word.
interface mtf_cfg_if;
  logic valid;
  logic ready;
  logic decode_mode;

  modport source (output valid, output decode_mode, input ready);
  modport sink (input valid, input decode_mode, output ready);
endinterface

// ----- hw/rtl/mtf_cell.sv -----
// One cell of the recency list: holds one entry and passes the search token on.
module mtf_cell import mtf_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = DEF_ALPHABET_SIZE,
  parameter int unsigned IDX = 0,
  localparam int unsigned EntryW = $clog2(ALPHABET_SIZE)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              decode_i,
  input  logic [EntryW-1:0] sym_i,
  input  logic              init_i,
  input  logic              front_we_i,
  input  logic [EntryW-1:0] front_val_i,
  input  mtf_tok_t          tok_i,
  input  logic [EntryW-1:0] carry_i,
  output mtf_tok_t          tok_o,
  output logic [EntryW-1:0] carry_o
);

  localparam logic [EntryW-1:0] Ident = EntryW'(IDX);

  logic [EntryW-1:0] entry_q, entry_d;
  logic [EntryW-1:0] carry_q;
  mtf_tok_t          tok_q, tok_d;
  logic              searching;
  logic              hit;
  logic              shift;

  assign searching = tok_i.active & ~tok_i.found;
  assign hit       = searching & (decode_i ? (sym_i == Ident) : (entry_q == sym_i));
  assign shift     = searching;

  always_comb begin
    entry_d = entry_q;
    if (init_i) begin
      entry_d = Ident;
    end else if (front_we_i && (IDX == 0)) begin
      entry_d = front_val_i;
    end else if (shift) begin
      entry_d = carry_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.val   = SYM_W'(entry_q);
      tok_d.pos   = SYM_W'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= Ident;
      tok_q   <= '0;
    end else begin
      entry_q <= entry_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.active) begin
      carry_q <= entry_q;
    end
  end

  assign tok_o   = tok_q;
  assign carry_o = carry_q;

endmodule

// ----- hw/rtl/move_to_front_codec_core.sv -----
// Top level of the byte move-to-front codec built as a row of list cells.
// A search token walks the cell row one cell per cycle. A new word is taken
// only after the previous word's result has been loaded into the output
// register, so a stalled result word delays the next one.
// Reset is asynchronous and active low; it restores the identity list and encode mode.
module move_to_front_codec_core import mtf_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mtf_in_if.sink    in_i,
  mtf_out_if.source out_o,
  mtf_cfg_if.sink   cfg_i
);

  localparam int unsigned EntryW = $clog2(ALPHABET_SIZE);
  localparam logic [SYM_W-1:0] SymMax = SYM_W'(ALPHABET_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic              dec_q;
  logic [EntryW-1:0] sym_q;
  logic              last_q;
  logic              start_q;
  mtf_tok_t          fin_q;
  logic              out_valid_q, out_valid_d;
  logic [SYM_W-1:0]  out_val_q;

  logic [SYM_W-1:0]  sym_sat;
  logic              in_acc;
  logic              out_free;
  logic              finish;
  logic              init;

  mtf_tok_t          tok [ALPHABET_SIZE+1];
  logic [EntryW-1:0] carry [ALPHABET_SIZE];

  assign sym_sat  = (in_i.symbol_in > SymMax) ? SymMax : in_i.symbol_in;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc   = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;
  assign finish   = (state_q == S_FIN) & out_free;
  assign init     = finish & last_q;

  assign cfg_i.ready = 1'b1;

  assign tok[0]   = '{active: start_q, found: 1'b0, val: '0, pos: '0};
  assign carry[0] = '0;

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    if (i < ALPHABET_SIZE - 1) begin : g_mid
      mtf_cell #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .IDX          (i)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .decode_i   (dec_q),
        .sym_i      (sym_q),
        .init_i     (init),
        .front_we_i (finish),
        .front_val_i(fin_q.val[EntryW-1:0]),
        .tok_i      (tok[i]),
        .carry_i    (carry[i]),
        .tok_o      (tok[i+1]),
        .carry_o    (carry[i+1])
      );
    end else begin : g_last
      mtf_cell #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .IDX          (i)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .decode_i   (dec_q),
        .sym_i      (sym_q),
        .init_i     (init),
        .front_we_i (finish),
        .front_val_i(fin_q.val[EntryW-1:0]),
        .tok_i      (tok[i]),
        .carry_i    (carry[i]),
        .tok_o      (tok[i+1]),
        .carry_o    ()
      );
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (tok[ALPHABET_SIZE].active) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dec_q       <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= in_acc;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        dec_q <= cfg_i.decode_mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sym_q  <= sym_sat[EntryW-1:0];
      last_q <= in_i.last_of_block;
    end
    if ((state_q == S_RUN) && tok[ALPHABET_SIZE].active) begin
      fin_q <= tok[ALPHABET_SIZE];
    end
    if (finish) begin
      out_val_q <= dec_q ? fin_q.val : fin_q.pos;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = out_val_q;

endmodule

// ----- hw/rtl/mtf_checker.sv -----
// Port-level checks for the move-to-front codec and their binding to the top level.
module mtf_checker import mtf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SYM_W-1:0] out_value
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("Result word dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("Result word changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken again while a word is still in the cell row.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $rose(in_ready))
    else $error("Result word appeared without the codec returning to idle.");

endmodule

bind move_to_front_codec_core mtf_checker u_mtf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_i.valid),
  .in_ready (in_i.ready),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_value(out_o.value_out)
);
